FILE: sv/pngse_pkg.sv
// shared types, constants and helper functions of the png stored-stream encoder
package pngse_pkg;

	localparam int unsigned MAX_DIM = 16384;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
	localparam logic [7:0]  ZLIB_CMF  = 8'h78;
	localparam logic [7:0]  ZLIB_FLG  = 8'h01;

	// register indexes of the configuration channel
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_ALPHA  = 2'd2;

	// last step index of each output burst
	localparam logic [5:0] HDR_LAST = 6'd42;
	localparam logic [5:0] BLK_LAST = 6'd4;
	localparam logic [5:0] TRL_LAST = 6'd19;

	typedef struct packed {
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic        has_alpha;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       row_start;
		logic       last;
	} item_t;

	typedef enum logic [3:0] {
		ST_RAW = 4'b0001,
		ST_HDR = 4'b0010,
		ST_BLK = 4'b0100,
		ST_TRL = 4'b1000
	} st_t;

	function automatic logic [14:0] clamp_dim(input logic [14:0] v);
		logic [14:0] r;
		if (v == 15'd0) r = 15'd1;
		else if (v > 15'(MAX_DIM)) r = 15'(MAX_DIM);
		else r = v;
		return r;
	endfunction

	function automatic logic [16:0] row_bytes(input cfg_t c);
		logic [14:0] w;
		logic [16:0] r;
		w = clamp_dim(c.image_width);
		if (c.has_alpha) r = {w, 2'b00};
		else r = {1'b0, w, 1'b0} + {2'b00, w};
		return r;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

FILE: sv/pngse_front.sv
// front end: configuration registers, pixel classification and item queue
module pngse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [14:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	output pngse_pkg::cfg_t      cfg,
	output logic                 head_valid,
	output pngse_pkg::item_t     head,
	input  logic                 pop
);

	pngse_pkg::cfg_t  cfg_q;
	pngse_pkg::item_t fifo_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  cnt_q;
	logic [16:0] col_q;
	logic [14:0] row_q;
	logic        busy_q;

	logic [16:0] rb;
	logic [14:0] hc;
	logic        row_end, last, push;
	pngse_pkg::item_t item;

	assign cfg_ready  = 1'b1;
	assign cfg        = cfg_q;
	assign s_tready   = (cnt_q != 3'd4);
	assign push       = s_tvalid & s_tready;
	assign head_valid = (cnt_q != 3'd0);
	assign head       = fifo_q[rd_ptr_q];

	assign rb      = pngse_pkg::row_bytes(cfg_q);
	assign hc      = pngse_pkg::clamp_dim(cfg_q.image_height);
	assign row_end = ((col_q + 17'd1) == rb);
	assign last    = row_end && (row_q == (hc - 15'd1));

	always_comb begin
		item.data      = s_tdata;
		item.first     = ~busy_q;
		item.row_start = (col_q == 17'd0);
		item.last      = last;
	end

	// writes in the middle of an image are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 15'd1;
			cfg_q.image_height <= 15'd1;
			cfg_q.has_alpha    <= 1'b0;
		end else if (cfg_valid && !busy_q) begin
			case (cfg_index)
				pngse_pkg::CFG_WIDTH:  cfg_q.image_width  <= cfg_data;
				pngse_pkg::CFG_HEIGHT: cfg_q.image_height <= cfg_data;
				pngse_pkg::CFG_ALPHA:  cfg_q.has_alpha    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
			col_q    <= 17'd0;
			row_q    <= 15'd0;
			busy_q   <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
			if (push) begin
				busy_q <= ~last;
				if (row_end) begin
					col_q <= 17'd0;
					row_q <= last ? 15'd0 : row_q + 15'd1;
				end else begin
					col_q <= col_q + 17'd1;
				end
			end
		end
	end

endmodule

FILE: sv/pngse_back.sv
// back end: byte sequencer for headers, stored blocks and trailer, with crc and adler
module pngse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pngse_pkg::cfg_t      cfg,
	input  logic                 head_valid,
	input  pngse_pkg::item_t     head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);

	pngse_pkg::st_t st_q, eff_st;
	logic [5:0]  idx_q, eff_idx;
	logic        hdr_done_q, filt_done_q;
	logic [31:0] crc_q, crc_inv, idat_q;
	logic [15:0] adl_lo_q, adl_hi_q, blk_rem_q;
	logic [30:0] raw_rem_q;
	logic        out_valid_q, out_last_q;
	logic [7:0]  out_byte_q;

	logic        have, fire, is_filt, crc_en, crc_rst, eof;
	logic [7:0]  b;
	logic [15:0] len, lo_n, hi_n, q0, blocks;
	logic        final_blk;
	logic [14:0] wc, hc;
	logic [30:0] raw_calc;
	logic [31:0] t, idat_calc;
	logic [16:0] r0, lo17, hi17;

	assign crc_inv = ~crc_q;
	assign wc = pngse_pkg::clamp_dim(cfg.image_width);
	assign hc = pngse_pkg::clamp_dim(cfg.image_height);
	assign raw_calc = {14'd0, pngse_pkg::row_bytes(cfg) + 17'd1} * {16'd0, hc};

	// blocks = ceil(raw / 65535) from the 2^16 - 1 folding identity
	assign t  = {1'b0, raw_rem_q} + 32'd65534;
	assign q0 = t[31:16];
	assign r0 = {1'b0, t[15:0]} + {1'b0, q0};
	assign blocks = q0 + ((r0 >= {1'b0, pngse_pkg::BLOCK_MAX}) ? 16'd1 : 16'd0);
	assign idat_calc = 32'd6 + {1'b0, raw_rem_q} + {14'd0, blocks, 2'b00} + {16'd0, blocks};

	assign len = (raw_rem_q < {15'd0, pngse_pkg::BLOCK_MAX}) ? raw_rem_q[15:0]
		: pngse_pkg::BLOCK_MAX;
	assign final_blk = ({15'd0, len} == raw_rem_q);
	assign is_filt = head.row_start && !filt_done_q;

	always_comb begin
		eff_st  = st_q;
		eff_idx = idx_q;
		have    = 1'b1;
		if (st_q == pngse_pkg::ST_RAW) begin
			have    = head_valid;
			eff_idx = 6'd0;
			if (head.first && !hdr_done_q) eff_st = pngse_pkg::ST_HDR;
			else if (blk_rem_q == 16'd0) eff_st = pngse_pkg::ST_BLK;
			else eff_st = pngse_pkg::ST_RAW;
		end
	end

	assign fire = have && (!out_valid_q || m_tready);
	assign pop  = fire && (eff_st == pngse_pkg::ST_RAW) && !is_filt;

	always_comb begin
		b       = 8'h00;
		crc_en  = 1'b0;
		crc_rst = 1'b0;
		eof     = 1'b0;
		case (eff_st)
			pngse_pkg::ST_HDR: begin
				crc_en = 1'b1;
				case (eff_idx)
					6'd0:  begin b = 8'h89; crc_en = 1'b0; end
					6'd1:  begin b = 8'h50; crc_en = 1'b0; end
					6'd2:  begin b = 8'h4E; crc_en = 1'b0; end
					6'd3:  begin b = 8'h47; crc_en = 1'b0; end
					6'd4:  begin b = 8'h0D; crc_en = 1'b0; end
					6'd5:  begin b = 8'h0A; crc_en = 1'b0; end
					6'd6:  begin b = 8'h1A; crc_en = 1'b0; end
					6'd7:  begin b = 8'h0A; crc_en = 1'b0; end
					6'd8, 6'd9, 6'd10: crc_en = 1'b0;
					6'd11: begin b = 8'h0D; crc_en = 1'b0; end
					6'd12: begin b = 8'h49; crc_rst = 1'b1; end
					6'd13: b = 8'h48;
					6'd14: b = 8'h44;
					6'd15: b = 8'h52;
					6'd18: b = {1'b0, wc[14:8]};
					6'd19: b = wc[7:0];
					6'd22: b = {1'b0, hc[14:8]};
					6'd23: b = hc[7:0];
					6'd24: b = 8'h08;
					6'd25: b = cfg.has_alpha ? 8'h06 : 8'h02;
					6'd29: begin b = crc_inv[31:24]; crc_en = 1'b0; end
					6'd30: begin b = crc_inv[23:16]; crc_en = 1'b0; end
					6'd31: begin b = crc_inv[15:8];  crc_en = 1'b0; end
					6'd32: begin b = crc_inv[7:0];   crc_en = 1'b0; end
					6'd33: begin b = idat_q[31:24]; crc_en = 1'b0; end
					6'd34: begin b = idat_q[23:16]; crc_en = 1'b0; end
					6'd35: begin b = idat_q[15:8];  crc_en = 1'b0; end
					6'd36: begin b = idat_q[7:0];   crc_en = 1'b0; end
					6'd37: begin b = 8'h49; crc_rst = 1'b1; end
					6'd38: b = 8'h44;
					6'd39: b = 8'h41;
					6'd40: b = 8'h54;
					6'd41: b = pngse_pkg::ZLIB_CMF;
					6'd42: b = pngse_pkg::ZLIB_FLG;
					default: b = 8'h00;
				endcase
			end
			pngse_pkg::ST_BLK: begin
				crc_en = 1'b1;
				case (eff_idx)
					6'd0:    b = {7'd0, final_blk};
					6'd1:    b = len[7:0];
					6'd2:    b = len[15:8];
					6'd3:    b = ~len[7:0];
					default: b = ~len[15:8];
				endcase
			end
			pngse_pkg::ST_TRL: begin
				case (eff_idx)
					6'd0:  begin b = adl_hi_q[15:8]; crc_en = 1'b1; end
					6'd1:  begin b = adl_hi_q[7:0];  crc_en = 1'b1; end
					6'd2:  begin b = adl_lo_q[15:8]; crc_en = 1'b1; end
					6'd3:  begin b = adl_lo_q[7:0];  crc_en = 1'b1; end
					6'd4:  b = crc_inv[31:24];
					6'd5:  b = crc_inv[23:16];
					6'd6:  b = crc_inv[15:8];
					6'd7:  b = crc_inv[7:0];
					6'd12: begin b = 8'h49; crc_en = 1'b1; crc_rst = 1'b1; end
					6'd13: begin b = 8'h45; crc_en = 1'b1; end
					6'd14: begin b = 8'h4E; crc_en = 1'b1; end
					6'd15: begin b = 8'h44; crc_en = 1'b1; end
					6'd16: b = crc_inv[31:24];
					6'd17: b = crc_inv[23:16];
					6'd18: b = crc_inv[15:8];
					6'd19: begin b = crc_inv[7:0]; eof = 1'b1; end
					default: b = 8'h00;
				endcase
			end
			default: begin
				b      = is_filt ? 8'h00 : head.data;
				crc_en = 1'b1;
			end
		endcase
	end

	// adler-32 step over one raw byte
	always_comb begin
		lo17 = {1'b0, adl_lo_q} + {9'd0, b};
		lo_n = (lo17 >= pngse_pkg::ADLER_MOD) ? 16'(lo17 - pngse_pkg::ADLER_MOD) : lo17[15:0];
		hi17 = {1'b0, adl_hi_q} + {1'b0, lo_n};
		hi_n = (hi17 >= pngse_pkg::ADLER_MOD) ? 16'(hi17 - pngse_pkg::ADLER_MOD) : hi17[15:0];
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= b;
			out_last_q <= eof;
			if (crc_en) crc_q <= pngse_pkg::crc_byte(crc_rst ? 32'hFFFFFFFF : crc_q, b);
			case (eff_st)
				pngse_pkg::ST_HDR: begin
					if (eff_idx == 6'd0) begin
						raw_rem_q <= raw_calc;
						adl_lo_q  <= 16'd1;
						adl_hi_q  <= 16'd0;
					end
					if (eff_idx == 6'd1) idat_q <= idat_calc;
				end
				pngse_pkg::ST_RAW: begin
					raw_rem_q <= raw_rem_q - 31'd1;
					adl_lo_q  <= lo_n;
					adl_hi_q  <= hi_n;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pngse_pkg::ST_RAW;
			idx_q       <= 6'd0;
			hdr_done_q  <= 1'b0;
			filt_done_q <= 1'b0;
			blk_rem_q   <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (fire) begin
				case (eff_st)
					pngse_pkg::ST_HDR: begin
						if (eff_idx == 6'd0) blk_rem_q <= 16'd0;
						if (eff_idx == pngse_pkg::HDR_LAST) begin
							st_q       <= pngse_pkg::ST_RAW;
							hdr_done_q <= 1'b1;
						end else begin
							st_q  <= pngse_pkg::ST_HDR;
							idx_q <= eff_idx + 6'd1;
						end
					end
					pngse_pkg::ST_BLK: begin
						if (eff_idx == pngse_pkg::BLK_LAST) begin
							st_q      <= pngse_pkg::ST_RAW;
							blk_rem_q <= len;
						end else begin
							st_q  <= pngse_pkg::ST_BLK;
							idx_q <= eff_idx + 6'd1;
						end
					end
					pngse_pkg::ST_TRL: begin
						if (eff_idx == pngse_pkg::TRL_LAST) st_q <= pngse_pkg::ST_RAW;
						else idx_q <= eff_idx + 6'd1;
					end
					default: begin
						blk_rem_q <= blk_rem_q - 16'd1;
						if (is_filt) begin
							filt_done_q <= 1'b1;
						end else begin
							filt_done_q <= 1'b0;
							hdr_done_q  <= 1'b0;
							if (head.last) begin
								st_q  <= pngse_pkg::ST_TRL;
								idx_q <= 6'd0;
							end
						end
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: sv/png_stored_stream_encoder_unit.sv
// top level of the png stored-stream encoder
// a pixel's byte enters the output register as the back end takes it from the queue
// throughput: one output byte per cycle while m_tready is high; an input byte per
// cycle except where the first pixel adds 43 header bytes, a stored block 5, a row
// a filter byte and the last pixel 20 trailer bytes, set by the single-byte back end
// reset: arst_n clears queue, counters and output; width and height go to 1, rgb
module png_stored_stream_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // pixel_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast    // end_of_file
);

	pngse_pkg::cfg_t  cfg;
	pngse_pkg::item_t head;
	logic             head_valid, pop;

	pngse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pngse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: sv/pngse_checker.sv
// port-level checker of the png stored-stream encoder and its bind
module pngse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [14:0] cfg_data,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	logic       sig_q;
	logic [6:0] cnt_q;
	logic       xfer;

	assign xfer = m_tvalid & m_tready;

	// track file boundaries and file length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= 1'b1;
			cnt_q <= 7'd0;
		end else if (xfer) begin
			sig_q <= m_tlast;
			if (m_tlast) cnt_q <= 7'd0;
			else if (cnt_q != 7'd127) cnt_q <= cnt_q + 7'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transfer changed");

	a_sig: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && sig_q |-> m_tdata == 8'h89)
		else $error("file does not open with the png signature");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && m_tlast |-> cnt_q >= 7'd71)
		else $error("end of file flagged too early");

endmodule

bind png_stored_stream_encoder_unit pngse_checker u_pngse_checker (.*);

FILE: dv/tb.sv
// testbench of the png stored-stream encoder: byte-exact check of the png file stream
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0]  CFG_UNUSED   = 2'd3;
	localparam int unsigned MAX_SIDE     = 16384;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned SETTLE_WAIT  = 40;
	localparam int unsigned RANDOM_ITEMS = 300;

	typedef struct {
		logic [7:0] data;
		logic       eof;
	} png_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // pixel_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte
	logic        m_tlast;   // end_of_file

	logic [7:0]  pixel_q[$];
	png_byte_t   png_q[$];
	int unsigned errors;
	int unsigned bytes_out;
	int unsigned random_sent;
	bit          steady;

	// encoder state as seen by the predictor
	int unsigned img_w, img_h;
	bit          img_alpha;
	bit          streaming;
	int unsigned col, raw_left, blk_left;
	logic [31:0] crc;
	int unsigned adl_lo, adl_hi;

	png_stored_stream_encoder_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned side_len(input int unsigned v);
		if (v == 0) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	function automatic int unsigned row_len();
		return side_len(img_w) * (img_alpha ? 4 : 3);
	endfunction

	task automatic put_byte(input int unsigned b, input bit crc_it);
		logic [31:0] c;
		c = crc ^ (b & 32'hFF);
		if (crc_it) begin
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
			crc = c;
		end
		png_q.insert(png_q.size(), '{data: b[7:0], eof: 1'b0});
	endtask

	task automatic put_word(input logic [31:0] v, input bit crc_it);
		put_byte(v[31:24], crc_it);
		put_byte(v[23:16], crc_it);
		put_byte(v[15:8], crc_it);
		put_byte(v[7:0], crc_it);
	endtask

	task automatic chunk_begin(input logic [31:0] len, input string tag);
		put_word(len, 1'b0);
		crc = '1;
		for (int i = 0; i < 4; i++) put_byte(tag[i], 1'b1);
	endtask

	task automatic chunk_end();
		put_word(~crc, 1'b0);
	endtask

	// one scanline byte into the zlib stream, opening a stored block when needed
	task automatic raw_byte(input logic [7:0] b);
		int unsigned len;
		logic [15:0] inv;
		if (blk_left == 0) begin
			len = raw_left < 65535 ? raw_left : 65535;
			inv = ~len[15:0];
			put_byte(len == raw_left, 1'b1);
			put_byte(len[7:0], 1'b1);
			put_byte(len[15:8], 1'b1);
			put_byte(inv[7:0], 1'b1);
			put_byte(inv[15:8], 1'b1);
			blk_left = len;
		end
		put_byte(b, 1'b1);
		if (blk_left) blk_left--;
		if (raw_left) raw_left--;
		adl_lo += b;
		if (adl_lo >= 65521) adl_lo -= 65521;
		adl_hi += adl_lo;
		if (adl_hi >= 65521) adl_hi -= 65521;
	endtask

	task automatic start_file();
		int unsigned blocks;
		raw_left = (row_len() + 1) * side_len(img_h);
		blocks = (raw_left + 65534) / 65535;
		put_word(32'h89504E47, 1'b0);
		put_word(32'h0D0A1A0A, 1'b0);
		chunk_begin(13, "IHDR");
		put_word(side_len(img_w), 1'b1);
		put_word(side_len(img_h), 1'b1);
		put_byte(8, 1'b1);
		put_byte(img_alpha ? 6 : 2, 1'b1);
		put_byte(0, 1'b1);
		put_byte(0, 1'b1);
		put_byte(0, 1'b1);
		chunk_end();
		chunk_begin(2 + 5 * blocks + raw_left + 4, "IDAT");
		put_byte(pngse_pkg::ZLIB_CMF, 1'b1);
		put_byte(pngse_pkg::ZLIB_FLG, 1'b1);
		adl_lo = 1;
		adl_hi = 0;
		col = 0;
		blk_left = 0;
		streaming = 1'b1;
	endtask

	task automatic encode_pixel(input logic [7:0] px);
		if (!streaming) start_file();
		if (col == 0) raw_byte(8'h00);
		raw_byte(px);
		col++;
		if (col >= row_len()) col = 0;
		if (raw_left == 0) begin
			put_word({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
			chunk_end();
			chunk_begin(0, "IEND");
			chunk_end();
			png_q[png_q.size() - 1].eof = 1'b1;
			streaming = 1'b0;
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// pixel driver
	int unsigned send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				encode_pixel(s_tdata);
				void'(pixel_q.pop_front());
				send_gap = pick_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pixel_q[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off so the block backs up into its input
	int unsigned hold_cnt;
	bit          held;
	always @(posedge clk or negedge arst_n) begin
		int unsigned r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt = 0;
			held = 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (!held && bytes_out >= 160) begin
			held = 1'b1;
			hold_cnt = 500;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (steady || r < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				hold_cnt = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 50);
			end
		end
	end

	// output checker
	always @(posedge clk) begin
		png_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_out++;
			if (png_q.size() == 0) begin
				$error("unexpected output byte %02h", m_tdata);
				errors++;
			end else begin
				want = png_q.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.eof) begin
					$error("end_of_file: expected %0d, got %0d", want.eof, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int unsigned quiet;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else if (++quiet >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pngse_pkg::CFG_WIDTH:  img_w = val;
			pngse_pkg::CFG_HEIGHT: img_h = val;
			pngse_pkg::CFG_ALPHA:  img_alpha = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(posedge clk); while (pixel_q.size() > 0 || png_q.size() > 0 || s_tvalid);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic set_image(input logic [14:0] w, input logic [14:0] h, input bit a);
		write_reg(pngse_pkg::CFG_WIDTH, w);
		write_reg(pngse_pkg::CFG_HEIGHT, h);
		write_reg(pngse_pkg::CFG_ALPHA, {14'd0, a});
	endtask

	task automatic random_image(input int unsigned count);
		for (int i = 0; i < count; i++)
			pixel_q.insert(pixel_q.size(),
				($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
				: 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned n;
		errors = 0;
		bytes_out = 0;
		steady = 1'b0;
		img_w = 1;
		img_h = 1;
		img_alpha = 1'b0;
		streaming = 1'b0;
		col = 0;
		raw_left = 0;
		blk_left = 0;
		crc = '1;
		adl_lo = 1;
		adl_hi = 0;
		cfg_valid = 1'b0;
		cfg_index = pngse_pkg::CFG_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 1x1 rgb
		pixel_q.insert(pixel_q.size(), 8'h00);
		pixel_q.insert(pixel_q.size(), 8'hFF);
		pixel_q.insert(pixel_q.size(), 8'h80);
		drain();

		// zero sides count as one, unknown index has no effect
		set_image(15'd0, 15'd0, 1'b1);
		write_reg(CFG_UNUSED, 15'h7FFF);
		pixel_q.insert(pixel_q.size(), 8'hFF);
		pixel_q.insert(pixel_q.size(), 8'h55);
		pixel_q.insert(pixel_q.size(), 8'hAA);
		pixel_q.insert(pixel_q.size(), 8'h01);
		drain();

		// 2x2 rgb, extremes only, no idling; the long receiver hold lands here
		steady = 1'b1;
		set_image(15'd2, 15'd2, 1'b0);
		for (int i = 0; i < 12; i++) pixel_q.insert(pixel_q.size(), i[0] ? 8'hFF : 8'h00);
		drain();
		steady = 1'b0;

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			set_image(15'($urandom_range(1, 5)), 15'($urandom_range(1, 4)),
				1'($urandom_range(0, 1)));
			steady = ($urandom_range(0, 4) == 0);
			n = row_len() * side_len(img_h);
			random_image(n);
			random_sent += n;
			drain();
		end
		steady = 1'b0;

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
